// ===== sv/fws_pkg.sv =====
// shared types and constants for the flow window statistics block
package fws_pkg;

  typedef struct packed {
    logic [31:0] source_address;
    logic [63:0] timestamp_ns;
    logic [31:0] packet_count;
    logic [31:0] byte_count;
    logic [15:0] ack_flags;
    logic [15:0] syn_flags;
    logic [15:0] rst_flags;
    logic [15:0] urg_flags;
    logic [15:0] cwr_flags;
    logic [15:0] smallest_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] flow_address;
    logic [63:0] duration_ns;
    logic [63:0] packets_per_second;
    logic [63:0] bytes_per_second;
    logic [31:0] ack_total;
    logic [31:0] syn_total;
    logic [31:0] rst_total;
    logic [31:0] urg_total;
    logic [31:0] cwr_total;
    logic [23:0] mean_length;
    logic [15:0] window_min_length;
  } out_item_t;

  typedef struct packed {
    logic fresh;
    logic full;
  } job_ctl_t;

  typedef struct packed {
    logic [63:0]      start;
    logic [31:0]      packets;
    logic [47:0]      bytes;
    logic [4:0][31:0] flags;
    logic [16:0]      min_len;
  } slot_row_t;

  localparam int NUM_W = 88;
  localparam int DEN_W = 64;

  localparam logic [1:0] ST_ACCUM  = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [0:0]  REG_WINDOW   = 1'b0;
  localparam logic [39:0] WINDOW_RESET = 40'd1000000000;
  localparam logic [29:0] NS_PER_S     = 30'd1000000000;
  localparam logic [16:0] NONE_LEN     = 17'h10000;
  localparam logic [31:0] MAX32        = 32'hFFFFFFFF;
  localparam logic [47:0] MAX48        = 48'hFFFFFFFFFFFF;
  localparam logic [63:0] PPS_CAP      = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] BPS_CAP      = 64'hFF_FFFF_FFFF_FFFF;
  localparam logic [23:0] MEAN_CAP     = 24'hFFFFFF;

endpackage

// ===== sv/fws_div.sv =====
// restoring divider, one quotient bit per cycle
module fws_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fws_pkg::NUM_W-1:0]    num,
  input  logic [fws_pkg::DEN_W-1:0]    den,
  output logic                         done,
  output logic [fws_pkg::NUM_W-1:0]    quo
);

  logic [fws_pkg::DEN_W:0] rem;
  logic [fws_pkg::DEN_W:0] sh;
  logic [6:0]              cnt;
  logic                    running;
  logic                    qbit;

  always_comb begin
    sh   = {rem[fws_pkg::DEN_W-1:0], quo[fws_pkg::NUM_W-1]};
    qbit = (sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 7'(fws_pkg::NUM_W);
      end else if (running) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (running) begin
      rem <= qbit ? sh - {1'b0, den} : sh;
      quo <= {quo[fws_pkg::NUM_W-2:0], qbit};
    end
  end

endmodule

// ===== sv/fws_queue.sv =====
// two-entry queue between front and back
module fws_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] ent [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= din;
  end

endmodule

// ===== sv/fws_front.sv =====
// front: takes reports, finds or allocates the flow slot
module fws_front #(
  parameter int FLOW_SLOTS = 1024,
  parameter int SW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  fws_pkg::in_item_t   item,
  output logic                busy,
  output logic                q_push,
  input  logic                q_full,
  output fws_pkg::in_item_t   job_item,
  output fws_pkg::job_ctl_t   job_ctl,
  output logic [SW-1:0]       job_slot
);

  localparam int CW = $clog2(FLOW_SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [SW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [31:0]   addr_mem [FLOW_SLOTS];
  logic          alloc;
  logic          table_full;
  logic          accept;
  logic          hit;
  logic          last;

  assign busy       = (state != S_IDLE);
  assign accept     = start && (state == S_IDLE);
  assign table_full = (count == CW'(FLOW_SLOTS));
  assign hit        = (rd_data == job_item.source_address);
  assign last       = ((CW'(rd_addr) + CW'(1)) == count);
  assign alloc      = ((accept && count == '0) || (state == S_CMP && !hit && last))
                      && !table_full;
  assign q_push     = (state == S_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      if (alloc) count <= count + CW'(1);
      case (state)
        S_IDLE: begin
          if (accept) state <= (count == '0) ? S_PUSH : S_RD;
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (hit || last) state <= S_PUSH;
          else state <= S_RD;
        end
        S_PUSH: begin
          if (!q_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= addr_mem[rd_addr];
    if (alloc) addr_mem[SW'(count)] <= (accept ? item.source_address
                                                : job_item.source_address);
    if (accept) begin
      job_item      <= item;
      rd_addr       <= '0;
      job_slot      <= '0;
      job_ctl.fresh <= (count == '0);
      job_ctl.full  <= 1'b0;
    end else if (state == S_CMP) begin
      if (hit) begin
        job_slot      <= rd_addr;
        job_ctl.fresh <= 1'b0;
        job_ctl.full  <= 1'b0;
      end else if (last) begin
        job_slot      <= SW'(count);
        job_ctl.fresh <= !table_full;
        job_ctl.full  <= table_full;
      end else begin
        rd_addr <= rd_addr + SW'(1);
      end
    end
  end

endmodule

// ===== sv/fws_back.sv =====
// back: slot update, window close and feature computation
module fws_back #(
  parameter int FLOW_SLOTS = 1024,
  parameter int SW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [39:0]         window_ns,
  input  logic                q_empty,
  output logic                q_pop,
  input  fws_pkg::in_item_t   job_item,
  input  fws_pkg::job_ctl_t   job_ctl,
  input  logic [SW-1:0]       job_slot,
  output logic                strobe,
  output fws_pkg::out_item_t  result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DGO  = 3'd4;
  localparam logic [2:0] S_DW   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]          state;
  fws_pkg::in_item_t   it;
  fws_pkg::job_ctl_t   ctl;
  logic [SW-1:0]       slot;
  fws_pkg::slot_row_t  row_mem [FLOW_SLOTS];
  fws_pkg::slot_row_t  rd_row;
  fws_pkg::slot_row_t  base;
  fws_pkg::slot_row_t  upd;
  fws_pkg::slot_row_t  clr;
  logic [15:0]         inflag [5];
  logic [32:0]         fsum [5];
  logic [32:0]         psum;
  logic [48:0]         bsum;
  logic [63:0]         elapsed_c;
  logic                close;
  logic                row_we;

  logic [63:0] elapsed;
  logic [31:0] pk;
  logic [47:0] by;
  logic [1:0]  ph;
  logic [1:0]  mk;
  logic [47:0] mcand;
  logic [77:0] acc;
  logic [45:0] prod;
  logic        div_start;
  logic        div_done;
  logic [fws_pkg::NUM_W-1:0] div_num;
  logic [fws_pkg::DEN_W-1:0] div_den;
  logic [fws_pkg::NUM_W-1:0] quo;

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign strobe = (state == S_OUT);

  always_comb begin
    inflag[0] = it.ack_flags;
    inflag[1] = it.syn_flags;
    inflag[2] = it.rst_flags;
    inflag[3] = it.urg_flags;
    inflag[4] = it.cwr_flags;
    clr         = '0;
    clr.start   = it.timestamp_ns;
    clr.min_len = fws_pkg::NONE_LEN;
    base = ctl.fresh ? clr : rd_row;
    upd  = base;
    psum = {1'b0, base.packets} + {1'b0, it.packet_count};
    bsum = {1'b0, base.bytes} + 49'(it.byte_count);
    upd.packets = psum[32] ? fws_pkg::MAX32 : psum[31:0];
    upd.bytes   = bsum[48] ? fws_pkg::MAX48 : bsum[47:0];
    for (int k = 0; k < 5; k++) begin
      fsum[k]      = {1'b0, base.flags[k]} + 33'(inflag[k]);
      upd.flags[k] = fsum[k][32] ? fws_pkg::MAX32 : fsum[k][31:0];
    end
    if ({1'b0, it.smallest_length} < base.min_len) upd.min_len = {1'b0, it.smallest_length};
    elapsed_c = it.timestamp_ns - base.start;
    close     = (elapsed_c >= {24'b0, window_ns});
    row_we    = (state == S_UPD) && !ctl.full;
    prod      = mcand[47:32] * fws_pkg::NS_PER_S;
    div_start = (state == S_DGO);
    div_num   = (ph == 2'd2) ? {32'b0, by, 8'b0} : {2'b0, acc, 8'b0};
    div_den   = (ph == 2'd2) ? {32'b0, pk} : elapsed;
  end

  fws_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    rd_row <= row_mem[slot];
    if (row_we) row_mem[slot] <= close ? clr : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) state <= job_ctl.full ? S_OUT : S_RD;
        end
        S_RD:  state <= S_UPD;
        S_UPD: state <= close ? S_MUL : S_OUT;
        S_MUL: begin
          if (mk == 2'd0) state <= S_DGO;
        end
        S_DGO: state <= S_DW;
        S_DW: begin
          if (div_done) begin
            if (ph == 2'd0) state <= S_MUL;
            else if (ph == 2'd1) state <= S_DGO;
            else state <= S_OUT;
          end
        end
        S_OUT:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        it     <= job_item;
        ctl    <= job_ctl;
        slot   <= job_slot;
        result <= {(job_ctl.full ? fws_pkg::ST_FULL : fws_pkg::ST_ACCUM),
                   {($bits(fws_pkg::out_item_t) - 2){1'b0}}};
      end
      S_UPD: begin
        elapsed <= elapsed_c;
        pk      <= upd.packets;
        by      <= upd.bytes;
        ph      <= 2'd0;
        mk      <= 2'd2;
        mcand   <= {16'b0, upd.packets};
        acc     <= '0;
        if (close) begin
          result.status            <= fws_pkg::ST_CLOSED;
          result.flow_address      <= it.source_address;
          result.duration_ns       <= elapsed_c;
          result.ack_total         <= upd.flags[0];
          result.syn_total         <= upd.flags[1];
          result.rst_total         <= upd.flags[2];
          result.urg_total         <= upd.flags[3];
          result.cwr_total         <= upd.flags[4];
          result.window_min_length <= upd.min_len[16] ? 16'd0 : upd.min_len[15:0];
        end
      end
      S_MUL: begin
        acc   <= {acc[61:0], 16'b0} + 78'(prod);
        mcand <= {mcand[31:0], 16'b0};
        mk    <= mk - 2'd1;
      end
      S_DW: begin
        if (div_done) begin
          if (ph == 2'd0) begin
            result.packets_per_second <= (elapsed == '0) ? 64'd0 :
              (quo > fws_pkg::NUM_W'(fws_pkg::PPS_CAP)) ? fws_pkg::PPS_CAP : quo[63:0];
            ph    <= 2'd1;
            mk    <= 2'd2;
            mcand <= by;
            acc   <= '0;
          end else if (ph == 2'd1) begin
            result.bytes_per_second <= (elapsed == '0) ? 64'd0 :
              (quo > fws_pkg::NUM_W'(fws_pkg::BPS_CAP)) ? fws_pkg::BPS_CAP : quo[63:0];
            ph <= 2'd2;
          end else begin
            result.mean_length <= (pk == '0) ? 24'd0 :
              (quo > fws_pkg::NUM_W'(fws_pkg::MEAN_CAP)) ? fws_pkg::MEAN_CAP : quo[23:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/flow_window_statistics_core.sv =====
// top level of the per-flow windowed statistics table
// the front reads and compares one searched slot at a time, then the back reads, updates and strobes the result;
// a closing window adds two multiplies and three divisions in the back
// throughput: one report per front search or back pass, whichever is longer
// reset clears control state, the slot fill count and sets window_ns to one second
// results come on one strobe cycle each and are never held off
module flow_window_statistics_core #(
  parameter int FLOW_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fws_pkg::in_item_t   item,
  output logic                strobe,
  output fws_pkg::out_item_t  result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  localparam int SW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int QW = SW + $bits(fws_pkg::job_ctl_t) + $bits(fws_pkg::in_item_t);

  logic [39:0]        window_ns;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  fws_pkg::in_item_t  f_item;
  fws_pkg::job_ctl_t  f_ctl;
  logic [SW-1:0]      f_slot;
  fws_pkg::in_item_t  b_item;
  fws_pkg::job_ctl_t  b_ctl;
  logic [SW-1:0]      b_slot;
  logic [QW-1:0]      q_dout;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == fws_pkg::REG_WINDOW) ? {24'b0, window_ns} : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ns <= fws_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && paddr[3] == fws_pkg::REG_WINDOW) begin
      window_ns <= pwdata[39:0];
    end
  end

  fws_front #(.FLOW_SLOTS(FLOW_SLOTS), .SW(SW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .q_push   (q_push),
    .q_full   (q_full),
    .job_item (f_item),
    .job_ctl  (f_ctl),
    .job_slot (f_slot)
  );

  fws_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({f_slot, f_ctl, f_item}),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_slot, b_ctl, b_item} = q_dout;

  fws_back #(.FLOW_SLOTS(FLOW_SLOTS), .SW(SW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .window_ns (window_ns),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .job_item  (b_item),
    .job_ctl   (b_ctl),
    .job_slot  (b_slot),
    .strobe    (strobe),
    .result    (result)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("front not busy after transfer");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue push while full");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status != fws_pkg::ST_CLOSED |->
      result.flow_address == '0 && result.duration_ns == '0)
    else $error("open or dropped result carries features");

endmodule
